[sv/gpsfp_pkg.sv]
`default_nettype none

package gpsfp_pkg;

    localparam int STORE_DEPTH_DEF       = 20;
    localparam int TICK_COUNTER_BITS_DEF = 32;

    // Checksum covers bytes 0..CSUM_LAST, checksum byte sits at CSUM_POS
    localparam int CSUM_LAST   = 16;
    localparam int CSUM_POS    = 17;
    localparam int FIELD_BYTES = CSUM_LAST + 1;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_SUFFIX_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SUFFIX_SECOND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LOST_LIMIT    = 2'd2;

    localparam logic [7:0]  SUFFIX_FIRST_RST  = 8'd238;
    localparam logic [7:0]  SUFFIX_SECOND_RST = 8'd239;
    localparam logic [15:0] LOST_LIMIT_RST    = 16'd1000;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic               frame_good;
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic [7:0]         sat_count;
        logic [7:0]         hdop_tenths;
        logic signed [15:0] altitude_tenths;
        logic [15:0]        heading_hundredths;
        logic [15:0]        speed_tenths;
        logic               fix_lost;
    } out_t;

endpackage

`default_nettype wire

[sv/gps_frame_parser_with_watchdog.sv]
// GPS frame parser with fix-loss watchdog.
// Input channel (in_valid / in_stall / in_data): each transfer is either a
// received serial byte or one time tick. Every input transfer yields exactly
// one result transfer on the output channel (out_valid / out_stall / out_data)
// holding the current navigation fields, fix_lost and frame_good.
// A tick or an ordinary byte goes through the finish step to the output register.
// A byte that completes the end marker starts a walk over the frame store:
// one store read per cycle for bytes 0..17 through the single read port,
// XOR folding bytes 0..16 and comparing with byte 17; the item then goes
// to the finish step. in_stall is high while an item is being worked on.
// Configuration (cfg_we / cfg_index / cfg_data) writes the end-marker bytes
// and the loss limit; write only while the block is idle.
// Reset clears the store valid flags (unwritten bytes read as zero), counters
// and fields, sets fix_lost and loads the register defaults. If out_stall
// holds the result, the finished item waits in the finish step; the output
// register keeps it stable until taken, and input resumes once it is loaded.
`default_nettype none

module gps_frame_parser_with_watchdog
    import gpsfp_pkg::*;
#(
    parameter int STORE_DEPTH       = STORE_DEPTH_DEF,
    parameter int TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_t                    in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_t                        out_data,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int POS_W = $clog2(STORE_DEPTH);
    localparam int SR_W  = FIELD_BYTES * 8;
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(STORE_DEPTH - 1);
    localparam logic [POS_W-1:0] IDX_CSUM  = POS_W'(CSUM_POS);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]  suffix_first_reg, suffix_first_next;
    logic [7:0]  suffix_second_reg, suffix_second_next;
    logic [15:0] lost_limit_reg, lost_limit_next;

    logic [7:0] mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] store_vld_reg, store_vld_next;
    logic [7:0] rd_data_reg;
    logic       rd_ok_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       last_byte_reg, last_byte_next;
    logic [TICK_COUNTER_BITS-1:0] tsg_reg, tsg_next;
    logic [TICK_COUNTER_BITS-1:0] up_reg, up_next;

    logic signed [31:0] lat_reg, lat_next;
    logic signed [31:0] lon_reg, lon_next;
    logic [7:0]         sats_reg, sats_next;
    logic [7:0]         hdop_reg, hdop_next;
    logic signed [15:0] alt_reg, alt_next;
    logic [15:0]        heading_reg, heading_next;
    logic [15:0]        speed_reg, speed_next;
    logic               lost_reg, lost_next;
    logic               good_reg, good_next;

    logic [POS_W-1:0] idx_reg, idx_next;
    logic             issue_done_reg, issue_done_next;
    logic             dat_vld_reg, dat_vld_next;
    logic [POS_W-1:0] dat_idx_reg, dat_idx_next;
    logic [7:0]       xor_reg, xor_next;
    logic [SR_W-1:0]  sr_reg, sr_next;

    logic out_valid_reg, out_valid_next;
    out_t out_data_reg, out_data_next;

    logic in_accept;
    logic mem_we;
    logic can_load;
    logic lost_now;
    logic [7:0] rd_byte;
    logic [TICK_COUNTER_BITS-1:0] limit_ext;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign mem_we    = in_accept && (in_data.opcode == OP_BYTE);
    assign can_load  = !out_valid_reg || !out_stall;
    assign rd_byte   = rd_ok_reg ? rd_data_reg : 8'd0;
    assign limit_ext = {{(TICK_COUNTER_BITS-16){1'b0}}, lost_limit_reg};
    assign lost_now  = (tsg_reg > limit_ext) || (up_reg <= limit_ext);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pos_reg] <= in_data.rx_byte;
        end
        rd_data_reg <= mem[idx_reg];
    end

    always_comb
    begin
        state_next         = state_reg;
        suffix_first_next  = suffix_first_reg;
        suffix_second_next = suffix_second_reg;
        lost_limit_next    = lost_limit_reg;
        store_vld_next     = store_vld_reg;
        pos_next           = pos_reg;
        last_byte_next     = last_byte_reg;
        tsg_next           = tsg_reg;
        up_next            = up_reg;
        lat_next           = lat_reg;
        lon_next           = lon_reg;
        sats_next          = sats_reg;
        hdop_next          = hdop_reg;
        alt_next           = alt_reg;
        heading_next       = heading_reg;
        speed_next         = speed_reg;
        lost_next          = lost_reg;
        good_next          = good_reg;
        idx_next           = idx_reg;
        issue_done_next    = issue_done_reg;
        dat_vld_next       = (state_reg == ST_WALK) && !issue_done_reg;
        dat_idx_next       = idx_reg;
        xor_next           = xor_reg;
        sr_next            = sr_reg;
        out_valid_next     = out_valid_reg;
        out_data_next      = out_data_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SUFFIX_FIRST:  suffix_first_next  = cfg_data[7:0];
                REG_SUFFIX_SECOND: suffix_second_next = cfg_data[7:0];
                REG_LOST_LIMIT:    lost_limit_next    = cfg_data;
                default:           ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    good_next = 1'b0;
                    if (in_data.opcode == OP_TICK)
                    begin
                        up_next  = (&up_reg)  ? up_reg  : up_reg + 1'b1;
                        tsg_next = (&tsg_reg) ? tsg_reg : tsg_reg + 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        store_vld_next[pos_reg] = 1'b1;
                        if (last_byte_reg == suffix_first_reg &&
                            in_data.rx_byte == suffix_second_reg)
                        begin
                            // end marker: rewind and check the frame
                            pos_next        = '0;
                            idx_next        = '0;
                            issue_done_next = 1'b0;
                            xor_next        = 8'd0;
                            state_next      = ST_WALK;
                        end
                        else
                        begin
                            last_byte_next = in_data.rx_byte;
                            pos_next   = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_WALK:
            begin
                if (!issue_done_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == IDX_CSUM)
                    begin
                        issue_done_next = 1'b1;
                    end
                end
                if (dat_vld_reg)
                begin
                    if (dat_idx_reg == IDX_CSUM)
                    begin
                        if (xor_reg == rd_byte)
                        begin
                            good_next    = 1'b1;
                            tsg_next     = '0;
                            lat_next     = sr_reg[135:104];
                            lon_next     = sr_reg[103:72];
                            sats_next    = sr_reg[63:56];
                            hdop_next    = sr_reg[55:48];
                            alt_next     = sr_reg[47:32];
                            heading_next = sr_reg[31:16];
                            speed_next   = sr_reg[15:0];
                        end
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ rd_byte;
                        sr_next  = {sr_reg[SR_W-9:0], rd_byte};
                    end
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (can_load)
                begin
                    lost_next = lost_now;
                    if (lost_now)
                    begin
                        lat_next  = '0;
                        lon_next  = '0;
                        sats_next = '0;
                    end
                    out_valid_next                   = 1'b1;
                    out_data_next.frame_good         = good_reg;
                    out_data_next.latitude           = lost_now ? 32'sd0 : lat_reg;
                    out_data_next.longitude          = lost_now ? 32'sd0 : lon_reg;
                    out_data_next.sat_count          = lost_now ? 8'd0 : sats_reg;
                    out_data_next.hdop_tenths        = hdop_reg;
                    out_data_next.altitude_tenths    = alt_reg;
                    out_data_next.heading_hundredths = heading_reg;
                    out_data_next.speed_tenths       = speed_reg;
                    out_data_next.fix_lost           = lost_now;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            suffix_first_reg  <= SUFFIX_FIRST_RST;
            suffix_second_reg <= SUFFIX_SECOND_RST;
            lost_limit_reg    <= LOST_LIMIT_RST;
            store_vld_reg     <= '0;
            rd_ok_reg         <= 1'b0;
            pos_reg           <= '0;
            last_byte_reg     <= 8'd0;
            tsg_reg           <= '0;
            up_reg            <= '0;
            lat_reg           <= '0;
            lon_reg           <= '0;
            sats_reg          <= '0;
            hdop_reg          <= '0;
            alt_reg           <= '0;
            heading_reg       <= '0;
            speed_reg         <= '0;
            lost_reg          <= 1'b1;
            good_reg          <= 1'b0;
            idx_reg           <= '0;
            issue_done_reg    <= 1'b1;
            dat_vld_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            suffix_first_reg  <= suffix_first_next;
            suffix_second_reg <= suffix_second_next;
            lost_limit_reg    <= lost_limit_next;
            store_vld_reg     <= store_vld_next;
            rd_ok_reg         <= store_vld_reg[idx_reg];
            pos_reg           <= pos_next;
            last_byte_reg     <= last_byte_next;
            tsg_reg           <= tsg_next;
            up_reg            <= up_next;
            lat_reg           <= lat_next;
            lon_reg           <= lon_next;
            sats_reg          <= sats_next;
            hdop_reg          <= hdop_next;
            alt_reg           <= alt_next;
            heading_reg       <= heading_next;
            speed_reg         <= speed_next;
            lost_reg          <= lost_next;
            good_reg          <= good_next;
            idx_reg           <= idx_next;
            issue_done_reg    <= issue_done_next;
            dat_vld_reg       <= dat_vld_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dat_idx_reg  <= dat_idx_next;
        xor_reg      <= xor_next;
        sr_reg       <= sr_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

[tb/tb_gps_frame_parser_with_watchdog.sv]
`timescale 1ns / 1ps

module tb_gps_frame_parser_with_watchdog
    import gpsfp_pkg::*;
;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [31:0] TICK_SAT = 32'hFFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    gps_frame_parser_with_watchdog i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Mirror of the parser and watchdog state
    logic [7:0] frame_mem [STORE_DEPTH_DEF];
    int unsigned wr_pos = 0;
    logic [7:0] prev_byte = '0;
    logic [31:0] since_good = '0;
    logic [31:0] uptime = '0;
    out_t nav_state = '0;
    logic [7:0] sfx_first = SUFFIX_FIRST_RST;
    logic [7:0] sfx_second = SUFFIX_SECOND_RST;
    logic [15:0] lost_limit = LOST_LIMIT_RST;

    out_t nav_expected [$];
    logic [7:0] frame_fields [FIELD_BYTES];

    int gap_pct = 0;
    int stall_pct = 0;
    int tick_pct = 0;
    int items_sent = 0;
    int results_seen = 0;
    int good_seen = 0;
    int fix_held_seen = 0;
    int mismatch_cnt = 0;
    out_t want;

    function automatic out_t advance_parser(input in_t item);
        logic [7:0] x;
        int unsigned pos;
        logic good;
        out_t res;
        good = 1'b0;
        if (item.opcode == OP_BYTE)
        begin
            pos = wr_pos;
            frame_mem[pos] = item.rx_byte;
            if (prev_byte == sfx_first && item.rx_byte == sfx_second)
            begin
                // end marker: rewind, keep prev_byte as it was
                wr_pos = 0;
                x = '0;
                for (int k = 0; k <= CSUM_LAST; k++)
                    x = x ^ frame_mem[k];
                if (x == frame_mem[CSUM_POS])
                begin
                    good = 1'b1;
                    since_good = '0;
                    nav_state.latitude = {frame_mem[0], frame_mem[1], frame_mem[2],
                                          frame_mem[3]};
                    nav_state.longitude = {frame_mem[4], frame_mem[5], frame_mem[6],
                                           frame_mem[7]};
                    nav_state.sat_count = frame_mem[9];
                    nav_state.hdop_tenths = frame_mem[10];
                    nav_state.altitude_tenths = {frame_mem[11], frame_mem[12]};
                    nav_state.heading_hundredths = {frame_mem[13], frame_mem[14]};
                    nav_state.speed_tenths = {frame_mem[15], frame_mem[16]};
                end
            end
            else
            begin
                prev_byte = item.rx_byte;
                wr_pos = (pos == STORE_DEPTH_DEF - 1) ? 0 : pos + 1;
            end
        end
        else
        begin
            if (uptime != TICK_SAT)
                uptime = uptime + 1;
            if (since_good != TICK_SAT)
                since_good = since_good + 1;
        end
        if (since_good > {16'd0, lost_limit} || uptime <= {16'd0, lost_limit})
        begin
            nav_state.latitude = '0;
            nav_state.longitude = '0;
            nav_state.sat_count = '0;
            nav_state.fix_lost = 1'b1;
        end
        else
        begin
            nav_state.fix_lost = 1'b0;
        end
        res = nav_state;
        res.frame_good = good;
        return res;
    endfunction

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("mismatch on result %0d: %s expected %h got %h",
                         results_seen, name, exp_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (nav_expected.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result transfer: %h", out_data);
            end
            else
            begin
                want = nav_expected.pop_front();
                check_field("frame_good", 32'(want.frame_good), 32'(out_data.frame_good));
                check_field("latitude", want.latitude, out_data.latitude);
                check_field("longitude", want.longitude, out_data.longitude);
                check_field("sat_count", 32'(want.sat_count), 32'(out_data.sat_count));
                check_field("hdop_tenths", 32'(want.hdop_tenths),
                            32'(out_data.hdop_tenths));
                check_field("altitude_tenths", 32'(want.altitude_tenths),
                            32'(out_data.altitude_tenths));
                check_field("heading_hundredths", 32'(want.heading_hundredths),
                            32'(out_data.heading_hundredths));
                check_field("speed_tenths", 32'(want.speed_tenths),
                            32'(out_data.speed_tenths));
                check_field("fix_lost", 32'(want.fix_lost), 32'(out_data.fix_lost));
            end
            results_seen++;
            if (out_data.frame_good === 1'b1)
                good_seen++;
            if (out_data.fix_lost === 1'b0)
                fix_held_seen++;
        end
    end

    task automatic send_item(input in_t item);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        nav_expected.push_back(advance_parser(item));
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        in_t item;
        item.opcode = OP_BYTE;
        item.rx_byte = b;
        send_item(item);
    endtask

    task automatic send_tick();
        in_t item;
        item.opcode = OP_TICK;
        item.rx_byte = 8'($urandom_range(0, 255));
        send_item(item);
    endtask

    task automatic maybe_tick();
        if ($urandom_range(0, 99) < tick_pct)
            send_tick();
    endtask

    // Send frame_fields, its checksum and the end marker
    task automatic send_frame(input bit corrupt);
        logic [7:0] csum;
        logic [7:0] flip;
        csum = '0;
        for (int k = 0; k < FIELD_BYTES; k++)
            csum = csum ^ frame_fields[k];
        if (corrupt)
        begin
            flip = 8'($urandom_range(1, 255));
            csum = csum ^ flip;
        end
        for (int k = 0; k < FIELD_BYTES; k++)
        begin
            maybe_tick();
            send_byte(frame_fields[k]);
        end
        maybe_tick();
        send_byte(csum);
        maybe_tick();
        send_byte(sfx_first);
        maybe_tick();
        send_byte(sfx_second);
    endtask

    // Drop valid and hold until every transfer has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (nav_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_SUFFIX_FIRST:  sfx_first = data[7:0];
            REG_SUFFIX_SECOND: sfx_second = data[7:0];
            REG_LOST_LIMIT:    lost_limit = data;
            default: ;
        endcase
    endtask

    task automatic set_markers(input logic [7:0] sf, input logic [7:0] ss,
                               input logic [15:0] limit);
        logic [7:0] junk;
        wait_idle();
        // upper bits of the 8-bit registers must be dropped
        junk = 8'($urandom_range(0, 255));
        write_reg(REG_SUFFIX_FIRST, {junk, sf});
        junk = 8'($urandom_range(0, 255));
        write_reg(REG_SUFFIX_SECOND, {junk, ss});
        write_reg(REG_LOST_LIMIT, limit);
    endtask

    task automatic fill_random_fields();
        for (int k = 0; k < FIELD_BYTES; k++)
            frame_fields[k] = 8'($urandom_range(0, 255));
    endtask

    task automatic test_default_markers();
        gap_pct = 0;
        stall_pct = 0;
        tick_pct = 0;
        send_tick();
        send_byte(SUFFIX_FIRST_RST);
        send_byte(SUFFIX_SECOND_RST);
    endtask

    task automatic test_register_writes();
        logic [CFG_DATA_W-1:0] data;
        wait_idle();
        data = 16'($urandom_range(0, 65535));
        write_reg(REG_UNUSED, data);
        set_markers(8'h00, 8'hFF, 16'd0);
    endtask

    task automatic test_directed_frame();
        logic [7:0] bytes [FIELD_BYTES];
        bytes = '{8'h80, 8'h00, 8'h00, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h55,
                  8'hFF, 8'h01, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h01};
        for (int k = 0; k < FIELD_BYTES; k++)
            frame_fields[k] = bytes[k];
        send_tick();
        send_frame(1'b0);
        // last byte still holds the first marker byte, so this ends a frame again
        send_byte(sfx_second);
        send_tick();
    endtask

    task automatic test_random_traffic(input int target, input int gap, input int stall,
                                       input logic [7:0] sf, input logic [7:0] ss,
                                       input logic [15:0] limit);
        int r;
        int n;
        int stop;
        set_markers(sf, ss, limit);
        gap_pct = gap;
        stall_pct = stall;
        tick_pct = 25;
        stop = items_sent + target;
        while (items_sent < stop)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                while (wr_pos != 0)
                    send_byte(8'($urandom_range(0, 255)));
                fill_random_fields();
                send_frame($urandom_range(0, 99) < 15);
            end
            else if (r < 72)
            begin
                // frame cut short by an early end marker
                n = $urandom_range(1, 19);
                for (int k = 0; k < n; k++)
                    send_byte(8'($urandom_range(0, 255)));
                send_byte(sfx_first);
                send_byte(sfx_second);
            end
            else if (r < 84)
            begin
                n = $urandom_range(1, 30);
                for (int k = 0; k < n; k++)
                    send_byte(8'($urandom_range(0, 255)));
            end
            else if (r < 94)
            begin
                n = (lost_limit + 4 < 25) ? lost_limit + 4 : 25;
                n = $urandom_range(1, n);
                for (int k = 0; k < n; k++)
                    send_tick();
            end
            else
            begin
                send_byte(sfx_second);
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_drain_pause();
        set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'hFFFF);
        gap_pct = 59;
        stall_pct = 10;
        tick_pct = 25;
        while (wr_pos != 0)
            send_byte(8'($urandom_range(0, 255)));
        fill_random_fields();
        send_frame(1'b0);
        in_valid <= 1'b0;
        @(posedge clk);
        while (nav_expected.size() != 0)
            @(posedge clk);
        repeat (5) send_tick();
        repeat (3) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        for (int k = 0; k < STORE_DEPTH_DEF; k++)
            frame_mem[k] = '0;
        nav_state.fix_lost = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_markers();
        test_register_writes();
        test_directed_frame();
        test_random_traffic(90, 0, 0, 8'h00, 8'hFF, 16'd0);
        test_random_traffic(90, 59, 0, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 16'($urandom_range(1, 15)));
        test_random_traffic(90, 0, 59, 8'hFF, 8'h00, 16'd10);
        test_random_traffic(90, 10, 10, 8'h5A, 8'h5A, 16'd6);
        test_drain_pause();
        stall_pct = 0;
        wait_idle();
        repeat (40) @(posedge clk);
        $display("covered %0d byte and tick transfers, %0d results checked",
                 items_sent, results_seen);
        $display("%0d good frames, %0d results with fix held, %0d mismatches",
                 good_seen, fix_held_seen, mismatch_cnt);
        if (mismatch_cnt == 0 && nav_expected.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("%0d results never arrived", nav_expected.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout with %0d results outstanding", nav_expected.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
sv/gpsfp_pkg.sv
sv/gps_frame_parser_with_watchdog.sv
tb/tb_gps_frame_parser_with_watchdog.sv
